// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the modem command session RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define MCS_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked while out of reset.
`define MCS_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle implication violated");

`endif

// ===== rtl/core/mcs_pkg.sv =====
// Package for the modem command session: queue sizes, operation and state
// codes, request and result types. No dependencies.
`timescale 1ns / 1ps

package mcs_pkg;

  localparam int NORMAL_DEPTH = 8;
  localparam int HIGH_DEPTH   = 4;

  localparam int NORMAL_AW = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
  localparam int HIGH_AW   = (HIGH_DEPTH > 1) ? $clog2(HIGH_DEPTH) : 1;
  localparam int NORMAL_CW = $clog2(NORMAL_DEPTH + 1);
  localparam int HIGH_CW   = $clog2(HIGH_DEPTH + 1);

  localparam logic [2:0] OP_ENQ_NORMAL = 3'd0;
  localparam logic [2:0] OP_ENQ_HIGH   = 3'd1;
  localparam logic [2:0] OP_TICK       = 3'd2;
  localparam logic [2:0] OP_BYTE       = 3'd3;
  localparam logic [2:0] OP_LINE       = 3'd4;
  localparam logic [2:0] OP_TAKE      = 3'd5;
  localparam logic [2:0] OP_RESET      = 3'd6;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_WAITING = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;

  localparam int FL_OK     = 0;
  localparam int FL_ERR    = 1;
  localparam int FL_TMO    = 2;
  localparam int FL_PROMPT = 3;
  localparam int FL_PREFIX = 4;
  localparam int FL_LINE   = 5;

  localparam logic [7:0] PROMPT_CHAR = 8'h3e;

  typedef struct packed {
    logic [7:0]  tag;
    logic [7:0]  cmd;
    logic [3:0]  expect_mask;
    logic [31:0] timeout;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic        send_valid;
    logic [7:0]  send_cmd;
    logic        res_valid;
    logic        res_ok;
    logic        res_error;
    logic        res_timed_out;
    logic        res_got_prompt;
    logic        res_got_prefix;
    logic        res_has_line;
    logic [7:0]  res_line_id;
    logic [7:0]  res_tag;
  } res_t;

  // Controller to datapath.
  typedef struct packed {
    logic take_item;
    logic fetch;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic start_pend;
  } dp_sts_t;

endpackage

// ===== rtl/core/mcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mcs_ctrl.sv =====
// Handshake controller for the modem command session.
// Depends on mcs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  mcs_pkg::dp_sts_t sts,
  output mcs_pkg::dp_cmd_t cmd
);

  localparam logic PH_ACCEPT = 1'b0;
  localparam logic PH_FETCH  = 1'b1;

  logic phase_r, phase_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_fire;
  logic load_out;

  assign in_ready = (phase_r == PH_ACCEPT) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign load_out = (in_fire && !sts.start_pend) || (phase_r == PH_FETCH);

  always_comb begin
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
    case (phase_r)
      PH_ACCEPT: begin
        if (in_fire && sts.start_pend) begin
          phase_nxt = PH_FETCH;
        end
      end
      PH_FETCH: begin
        phase_nxt = PH_ACCEPT;
      end
      default: begin
        phase_nxt = PH_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ACCEPT;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.take_item = in_fire;
  assign cmd.fetch     = (phase_r == PH_FETCH);
  assign out_valid     = out_valid_r;

  `MCS_ASSERT_NXT(a_fetch_one_cycle, phase_r == PH_FETCH, phase_r == PH_ACCEPT)
  `MCS_ASSERT_IMP(a_fetch_slot_free, phase_r == PH_FETCH, !out_valid_r)
  `MCS_ASSERT_NXT(a_start_goes_fetch, in_fire && sts.start_pend, phase_r == PH_FETCH)

endmodule

// ===== rtl/core/mcs_datapath.sv =====
// Datapath of the modem command session: request queues, session state,
// deadline, result flags and the result register. Depends on mcs_pkg,
// mcs_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcs_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mcs_pkg::dp_cmd_t      cmd,
  output mcs_pkg::dp_sts_t      sts,
  input  logic [2:0]            in_operation,
  input  logic [31:0]           in_now_ms,
  input  logic [7:0]            in_req_tag,
  input  logic [7:0]            in_req_cmd,
  input  logic [3:0]            in_req_expect,
  input  logic [31:0]           in_req_timeout_ms,
  input  logic [7:0]            in_byte_value,
  input  logic                  in_line_empty,
  input  logic                  in_line_is_ok,
  input  logic                  in_line_is_error,
  input  logic                  in_line_prefix_match,
  input  logic [7:0]            in_line_id,
  output mcs_pkg::res_t         res
);

  localparam int NAW = mcs_pkg::NORMAL_AW;
  localparam int HAW = mcs_pkg::HIGH_AW;
  localparam int NCW = mcs_pkg::NORMAL_CW;
  localparam int HCW = mcs_pkg::HIGH_CW;

  localparam logic [NCW-1:0] NORMAL_FULL  = NCW'(mcs_pkg::NORMAL_DEPTH);
  localparam logic [HCW-1:0] HIGH_FULL    = HCW'(mcs_pkg::HIGH_DEPTH);
  localparam logic [NAW:0]   NORMAL_DEP_W = (NAW + 1)'(mcs_pkg::NORMAL_DEPTH);
  localparam logic [HAW:0]   HIGH_DEP_W   = (HAW + 1)'(mcs_pkg::HIGH_DEPTH);
  localparam logic [NAW-1:0] NORMAL_LAST  = NAW'(mcs_pkg::NORMAL_DEPTH - 1);
  localparam logic [HAW-1:0] HIGH_LAST    = HAW'(mcs_pkg::HIGH_DEPTH - 1);

  logic [NAW-1:0] nm_head_r, nm_head_nxt;
  logic [NCW-1:0] nm_cnt_r, nm_cnt_nxt;
  logic [HAW-1:0] hi_head_r, hi_head_nxt;
  logic [HCW-1:0] hi_cnt_r, hi_cnt_nxt;
  logic [1:0]     state_r, state_nxt;
  logic [5:0]     flags_r, flags_nxt;
  logic [7:0]     line_r, line_nxt;
  logic [31:0]    deadline_r, deadline_nxt;
  logic [31:0]    now_r, now_nxt;
  logic           sel_r, sel_nxt;
  mcs_pkg::req_t  act_r, act_nxt;
  mcs_pkg::res_t  res_r, res_nxt;

  mcs_pkg::req_t  new_req, nm_rd, hi_rd, fetch_req;
  logic           nm_we, hi_we;
  logic [NAW:0]   nm_sum, nm_wsum;
  logic [HAW:0]   hi_sum, hi_wsum;
  logic [31:0]    tick_diff;
  logic [31:0]    eff_timeout;
  logic [5:0]     lf;
  logic [7:0]     lc;
  logic           lfin;

  assign new_req.tag         = in_req_tag;
  assign new_req.cmd         = in_req_cmd;
  assign new_req.expect_mask = in_req_expect;
  assign new_req.timeout     = in_req_timeout_ms;

  // Tail slot is head plus count, folded back once into the ring.
  assign nm_sum  = {1'b0, nm_head_r} + (NAW + 1)'(nm_cnt_r);
  assign nm_wsum = (nm_sum >= NORMAL_DEP_W) ? (nm_sum - NORMAL_DEP_W) : nm_sum;
  assign hi_sum  = {1'b0, hi_head_r} + (HAW + 1)'(hi_cnt_r);
  assign hi_wsum = (hi_sum >= HIGH_DEP_W) ? (hi_sum - HIGH_DEP_W) : hi_sum;

  mcs_ram #(
    .WIDTH ($bits(mcs_pkg::req_t)),
    .DEPTH (mcs_pkg::NORMAL_DEPTH)
  ) u_normal_q (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_wsum[NAW-1:0]),
    .wdata (new_req),
    .raddr (nm_head_r),
    .rdata (nm_rd)
  );

  mcs_ram #(
    .WIDTH ($bits(mcs_pkg::req_t)),
    .DEPTH (mcs_pkg::HIGH_DEPTH)
  ) u_high_q (
    .clk   (clk),
    .we    (hi_we),
    .waddr (hi_wsum[HAW-1:0]),
    .wdata (new_req),
    .raddr (hi_head_r),
    .rdata (hi_rd)
  );

  assign fetch_req   = sel_r ? hi_rd : nm_rd;
  assign eff_timeout = (fetch_req.timeout == 32'd0) ? 32'd1 : fetch_req.timeout;
  assign tick_diff   = in_now_ms - deadline_r;

  // A tick in idle with a queued request must read it from the queue RAM before it completes.
  assign sts.start_pend = (in_operation == mcs_pkg::OP_TICK) &&
                          (state_r == mcs_pkg::ST_IDLE) &&
                          ((hi_cnt_r != '0) || (nm_cnt_r != '0));

  // Line evaluation against the expectation mask of the active request.
  always_comb begin
    lf   = flags_r;
    lc   = line_r;
    lfin = 1'b0;
    if (act_r.expect_mask[1] && in_line_prefix_match) begin
      lf[mcs_pkg::FL_PREFIX] = 1'b1;
      if (!lf[mcs_pkg::FL_LINE]) begin
        lc = in_line_id;
        lf[mcs_pkg::FL_LINE] = 1'b1;
      end
    end
    if (act_r.expect_mask[2] && in_line_is_ok) begin
      lf[mcs_pkg::FL_OK] = 1'b1;
      lfin = 1'b1;
    end else if (act_r.expect_mask[2] && in_line_is_error) begin
      if (!lf[mcs_pkg::FL_LINE]) begin
        lc = in_line_id;
        lf[mcs_pkg::FL_LINE] = 1'b1;
      end
      lf[mcs_pkg::FL_ERR] = 1'b1;
      lfin = 1'b1;
    end else if (act_r.expect_mask[3]) begin
      if (!lf[mcs_pkg::FL_LINE]) begin
        lc = in_line_id;
        lf[mcs_pkg::FL_LINE] = 1'b1;
      end
      lf[mcs_pkg::FL_OK] = 1'b1;
      lfin = 1'b1;
    end
  end

  always_comb begin
    nm_head_nxt  = nm_head_r;
    nm_cnt_nxt   = nm_cnt_r;
    hi_head_nxt  = hi_head_r;
    hi_cnt_nxt   = hi_cnt_r;
    state_nxt    = state_r;
    flags_nxt    = flags_r;
    line_nxt     = line_r;
    deadline_nxt = deadline_r;
    now_nxt      = now_r;
    sel_nxt      = sel_r;
    act_nxt      = act_r;
    res_nxt      = res_r;
    nm_we        = 1'b0;
    hi_we        = 1'b0;
    if (cmd.take_item) begin
      res_nxt = '0;
      now_nxt = in_now_ms;
      sel_nxt = (hi_cnt_r != '0);
      case (in_operation)
        mcs_pkg::OP_ENQ_NORMAL: begin
          if (nm_cnt_r != NORMAL_FULL) begin
            nm_we            = 1'b1;
            nm_cnt_nxt       = nm_cnt_r + 1'b1;
            res_nxt.accepted = 1'b1;
          end
        end
        mcs_pkg::OP_ENQ_HIGH: begin
          if (hi_cnt_r != HIGH_FULL) begin
            hi_we            = 1'b1;
            hi_cnt_nxt       = hi_cnt_r + 1'b1;
            res_nxt.accepted = 1'b1;
          end
        end
        mcs_pkg::OP_TICK: begin
          if ((state_r == mcs_pkg::ST_WAITING) && !tick_diff[31]) begin
            flags_nxt[mcs_pkg::FL_TMO] = 1'b1;
            state_nxt = mcs_pkg::ST_DONE;
          end
        end
        mcs_pkg::OP_BYTE: begin
          if ((state_r == mcs_pkg::ST_WAITING) && act_r.expect_mask[0] &&
              (in_byte_value == mcs_pkg::PROMPT_CHAR)) begin
            flags_nxt[mcs_pkg::FL_PROMPT] = 1'b1;
            flags_nxt[mcs_pkg::FL_OK]     = 1'b1;
            state_nxt = mcs_pkg::ST_DONE;
          end
        end
        mcs_pkg::OP_LINE: begin
          if ((state_r == mcs_pkg::ST_WAITING) && !in_line_empty) begin
            flags_nxt = lf;
            line_nxt  = lc;
            if (lfin) begin
              state_nxt = mcs_pkg::ST_DONE;
            end
          end
        end
        mcs_pkg::OP_TAKE: begin
          if (state_r == mcs_pkg::ST_DONE) begin
            res_nxt.res_valid      = 1'b1;
            res_nxt.res_ok         = flags_r[mcs_pkg::FL_OK];
            res_nxt.res_error      = flags_r[mcs_pkg::FL_ERR];
            res_nxt.res_timed_out  = flags_r[mcs_pkg::FL_TMO];
            res_nxt.res_got_prompt = flags_r[mcs_pkg::FL_PROMPT];
            res_nxt.res_got_prefix = flags_r[mcs_pkg::FL_PREFIX];
            res_nxt.res_has_line   = flags_r[mcs_pkg::FL_LINE];
            res_nxt.res_line_id    = line_r;
            res_nxt.res_tag        = act_r.tag;
            flags_nxt = '0;
            line_nxt  = '0;
            state_nxt = mcs_pkg::ST_IDLE;
          end
        end
        mcs_pkg::OP_RESET: begin
          nm_head_nxt  = '0;
          nm_cnt_nxt   = '0;
          hi_head_nxt  = '0;
          hi_cnt_nxt   = '0;
          state_nxt    = mcs_pkg::ST_IDLE;
          flags_nxt    = '0;
          line_nxt     = '0;
          deadline_nxt = '0;
          act_nxt      = '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.fetch) begin
      res_nxt = '0;
      if (sel_r) begin
        hi_head_nxt = (hi_head_r == HIGH_LAST) ? '0 : hi_head_r + 1'b1;
        hi_cnt_nxt  = hi_cnt_r - 1'b1;
      end else begin
        nm_head_nxt = (nm_head_r == NORMAL_LAST) ? '0 : nm_head_r + 1'b1;
        nm_cnt_nxt  = nm_cnt_r - 1'b1;
      end
      act_nxt            = fetch_req;
      flags_nxt          = '0;
      line_nxt           = '0;
      deadline_nxt       = now_r + eff_timeout;
      state_nxt          = mcs_pkg::ST_WAITING;
      res_nxt.send_valid = 1'b1;
      res_nxt.send_cmd   = fetch_req.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_head_r <= '0;
      nm_cnt_r  <= '0;
      hi_head_r <= '0;
      hi_cnt_r  <= '0;
      state_r   <= mcs_pkg::ST_IDLE;
      flags_r   <= '0;
      line_r    <= '0;
    end else begin
      nm_head_r <= nm_head_nxt;
      nm_cnt_r  <= nm_cnt_nxt;
      hi_head_r <= hi_head_nxt;
      hi_cnt_r  <= hi_cnt_nxt;
      state_r   <= state_nxt;
      flags_r   <= flags_nxt;
      line_r    <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deadline_r <= deadline_nxt;
    now_r      <= now_nxt;
    sel_r      <= sel_nxt;
    act_r      <= act_nxt;
    res_r      <= res_nxt;
  end

  assign res = res_r;

  `MCS_ASSERT_IMP(a_normal_count_bound, 1'b1, nm_cnt_r <= NORMAL_FULL)
  `MCS_ASSERT_IMP(a_high_count_bound, 1'b1, hi_cnt_r <= HIGH_FULL)
  `MCS_ASSERT_NXT(a_fetch_starts_wait, cmd.fetch, state_r == mcs_pkg::ST_WAITING)

endmodule

// ===== rtl/core/modem_command_session.sv =====
// Top level of the modem command session.
// Depends on mcs_pkg, mcs_ctrl, mcs_datapath and mcs_ram.
`timescale 1ns / 1ps
//
//   Channel  | Handshake             | Payload
//   ---------+-----------------------+-----------------------------------------
//   in_      | in_valid / in_ready   | operation, time, request, byte, line
//   out_     | out_valid / out_ready | accepted, send command, session result
//
// Every accepted transaction produces exactly one result transaction.
// A tick that starts a queued request passes through an extra fetch phase,
// because the request is read from the queue RAM with a registered read
// port. While the result register holds an untaken transaction, a new one
// is accepted only in the cycle the result is taken. Reset (rst_n low,
// synchronous) empties both queues and returns the session to idle; the
// queue RAMs need no clearing pass since only written slots are ever read.

module modem_command_session (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_now_ms,
  input  logic [7:0]  in_req_tag,
  input  logic [7:0]  in_req_cmd,
  input  logic [3:0]  in_req_expect,
  input  logic [31:0] in_req_timeout_ms,
  input  logic [7:0]  in_byte_value,
  input  logic        in_line_empty,
  input  logic        in_line_is_ok,
  input  logic        in_line_is_error,
  input  logic        in_line_prefix_match,
  input  logic [7:0]  in_line_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_send_valid,
  output logic [7:0]  out_send_cmd,
  output logic        out_res_valid,
  output logic        out_res_ok,
  output logic        out_res_error,
  output logic        out_res_timed_out,
  output logic        out_res_got_prompt,
  output logic        out_res_got_prefix,
  output logic        out_res_has_line,
  output logic [7:0]  out_res_line_id,
  output logic [7:0]  out_res_tag
);

  // The controller only sequences the handshake and the queue read cycle;
  // all session state lives in the datapath.
  mcs_pkg::dp_cmd_t dp_cmd;
  mcs_pkg::dp_sts_t dp_sts;
  mcs_pkg::res_t    res;

  mcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  mcs_datapath u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (dp_cmd),
    .sts                  (dp_sts),
    .in_operation         (in_operation),
    .in_now_ms            (in_now_ms),
    .in_req_tag           (in_req_tag),
    .in_req_cmd           (in_req_cmd),
    .in_req_expect        (in_req_expect),
    .in_req_timeout_ms    (in_req_timeout_ms),
    .in_byte_value        (in_byte_value),
    .in_line_empty        (in_line_empty),
    .in_line_is_ok        (in_line_is_ok),
    .in_line_is_error     (in_line_is_error),
    .in_line_prefix_match (in_line_prefix_match),
    .in_line_id           (in_line_id),
    .res                  (res)
  );

  // The result register is unpacked onto the individual result ports.
  assign out_accepted       = res.accepted;
  assign out_send_valid     = res.send_valid;
  assign out_send_cmd       = res.send_cmd;
  assign out_res_valid      = res.res_valid;
  assign out_res_ok         = res.res_ok;
  assign out_res_error      = res.res_error;
  assign out_res_timed_out  = res.res_timed_out;
  assign out_res_got_prompt = res.res_got_prompt;
  assign out_res_got_prefix = res.res_got_prefix;
  assign out_res_has_line   = res.res_has_line;
  assign out_res_line_id    = res.res_line_id;
  assign out_res_tag        = res.res_tag;

endmodule

// ===== dv/tb_modem_command_session.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for modem_command_session: a directed table followed by
// random command sessions, checked against fixed rows or a behavioral predictor.
// Depends on mcs_pkg and the modem_command_session RTL.

module tb_modem_command_session;

  // The package stops at the reset operation; the eighth code is a no-op.
  localparam logic [2:0] OP_IGNORED = 3'd7;

  localparam int unsigned OP_TARGET = 1600;
  localparam int CLK_HALF = 5;
  localparam int DRAIN_CYCLES = 20;
  localparam longint WATCHDOG_NS = 64'd10_000_000;

  // One input transaction, with every field at the width of its port.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now_ms;
    logic [7:0]  tag;
    logic [7:0]  cmd;
    logic [3:0]  expect_mask;
    logic [31:0] timeout;
    logic [7:0]  byte_value;
    logic        line_empty;
    logic        line_ok;
    logic        line_err;
    logic        line_prefix;
    logic [7:0]  line_id;
  } op_item_t;

  // A row of the directed table. Rows marked fixed carry a hand-typed result;
  // all other rows are checked against the predictor.
  typedef struct packed {
    op_item_t      item;
    logic          fixed;
    mcs_pkg::res_t want;
  } row_t;

  localparam mcs_pkg::res_t NO_RESULT = '0;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_operation;
  logic [31:0] in_now_ms;
  logic [7:0]  in_req_tag;
  logic [7:0]  in_req_cmd;
  logic [3:0]  in_req_expect;
  logic [31:0] in_req_timeout_ms;
  logic [7:0]  in_byte_value;
  logic        in_line_empty;
  logic        in_line_is_ok;
  logic        in_line_is_error;
  logic        in_line_prefix_match;
  logic [7:0]  in_line_id;
  logic        out_valid;
  logic        out_ready;
  logic        out_accepted;
  logic        out_send_valid;
  logic [7:0]  out_send_cmd;
  logic        out_res_valid;
  logic        out_res_ok;
  logic        out_res_error;
  logic        out_res_timed_out;
  logic        out_res_got_prompt;
  logic        out_res_got_prefix;
  logic        out_res_has_line;
  logic [7:0]  out_res_line_id;
  logic [7:0]  out_res_tag;

  modem_command_session i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_now_ms            (in_now_ms),
    .in_req_tag           (in_req_tag),
    .in_req_cmd           (in_req_cmd),
    .in_req_expect        (in_req_expect),
    .in_req_timeout_ms    (in_req_timeout_ms),
    .in_byte_value        (in_byte_value),
    .in_line_empty        (in_line_empty),
    .in_line_is_ok        (in_line_is_ok),
    .in_line_is_error     (in_line_is_error),
    .in_line_prefix_match (in_line_prefix_match),
    .in_line_id           (in_line_id),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_accepted         (out_accepted),
    .out_send_valid       (out_send_valid),
    .out_send_cmd         (out_send_cmd),
    .out_res_valid        (out_res_valid),
    .out_res_ok           (out_res_ok),
    .out_res_error        (out_res_error),
    .out_res_timed_out    (out_res_timed_out),
    .out_res_got_prompt   (out_res_got_prompt),
    .out_res_got_prefix   (out_res_got_prefix),
    .out_res_has_line     (out_res_has_line),
    .out_res_line_id      (out_res_line_id),
    .out_res_tag          (out_res_tag)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Session predictor. It mirrors the two request rings, the session state,
  // the deadline and the result flags of the block.
  // ---------------------------------------------------------------------------
  mcs_pkg::req_t normal_ring [mcs_pkg::NORMAL_DEPTH];
  mcs_pkg::req_t high_ring   [mcs_pkg::HIGH_DEPTH];
  int unsigned   normal_rd, normal_fill, high_rd, high_fill;
  logic [1:0]    sess_state;
  logic [31:0]   deadline_ms;
  mcs_pkg::req_t active_req;
  logic [5:0]    sess_flags;
  logic [7:0]    first_line;

  // Results still owed by the block, oldest first.
  mcs_pkg::res_t owed_results [$];
  row_t          directed_rows [$];
  int unsigned   fail_count = 0;
  int unsigned   ops_sent = 0;
  bit            calm_phase = 1'b0;

  function automatic void session_clear();
    foreach (normal_ring[i]) normal_ring[i] = '0;
    foreach (high_ring[i]) high_ring[i] = '0;
    normal_rd   = 0;
    normal_fill = 0;
    high_rd     = 0;
    high_fill   = 0;
    sess_state  = mcs_pkg::ST_IDLE;
    deadline_ms = '0;
    active_req  = '0;
    sess_flags  = '0;
    first_line  = '0;
  endfunction

  // Only the first captured line handle is kept for the result.
  function automatic void grab_line(input logic [7:0] id);
    if (!sess_flags[mcs_pkg::FL_LINE]) begin
      first_line = id;
      sess_flags[mcs_pkg::FL_LINE] = 1'b1;
    end
  endfunction

  // Applies one transaction to the predicted session and returns the result
  // the block owes for it.
  function automatic mcs_pkg::res_t session_step(input op_item_t it);
    mcs_pkg::res_t r;
    mcs_pkg::req_t rq;
    logic [31:0]   slack;
    bit            started;
    r = '0;
    started = 1'b0;
    rq.tag         = it.tag;
    rq.cmd         = it.cmd;
    rq.expect_mask = it.expect_mask;
    rq.timeout     = it.timeout;
    case (it.op)
      mcs_pkg::OP_ENQ_NORMAL: begin
        if (normal_fill < mcs_pkg::NORMAL_DEPTH) begin
          normal_ring[(normal_rd + normal_fill) % mcs_pkg::NORMAL_DEPTH] = rq;
          normal_fill++;
          r.accepted = 1'b1;
        end
      end
      mcs_pkg::OP_ENQ_HIGH: begin
        if (high_fill < mcs_pkg::HIGH_DEPTH) begin
          high_ring[(high_rd + high_fill) % mcs_pkg::HIGH_DEPTH] = rq;
          high_fill++;
          r.accepted = 1'b1;
        end
      end
      mcs_pkg::OP_TICK: begin
        if (sess_state == mcs_pkg::ST_IDLE) begin
          // High priority requests always go first.
          if (high_fill > 0) begin
            active_req = high_ring[high_rd];
            high_rd = (high_rd + 1) % mcs_pkg::HIGH_DEPTH;
            high_fill--;
            started = 1'b1;
          end else if (normal_fill > 0) begin
            active_req = normal_ring[normal_rd];
            normal_rd = (normal_rd + 1) % mcs_pkg::NORMAL_DEPTH;
            normal_fill--;
            started = 1'b1;
          end
          if (started) begin
            sess_flags  = '0;
            first_line  = '0;
            deadline_ms = it.now_ms +
                          ((active_req.timeout == '0) ? 32'd1 : active_req.timeout);
            sess_state  = mcs_pkg::ST_WAITING;
            r.send_valid = 1'b1;
            r.send_cmd   = active_req.cmd;
          end
        end else if (sess_state == mcs_pkg::ST_WAITING) begin
          // The deadline has passed once the 32-bit difference is not negative.
          slack = it.now_ms - deadline_ms;
          if (!slack[31]) begin
            sess_flags[mcs_pkg::FL_TMO] = 1'b1;
            sess_state = mcs_pkg::ST_DONE;
          end
        end
      end
      mcs_pkg::OP_BYTE: begin
        if (sess_state == mcs_pkg::ST_WAITING && active_req.expect_mask[0] &&
            it.byte_value == mcs_pkg::PROMPT_CHAR) begin
          sess_flags[mcs_pkg::FL_PROMPT] = 1'b1;
          sess_flags[mcs_pkg::FL_OK] = 1'b1;
          sess_state = mcs_pkg::ST_DONE;
        end
      end
      mcs_pkg::OP_LINE: begin
        if (sess_state == mcs_pkg::ST_WAITING && !it.line_empty) begin
          // A prefix match records itself but leaves the session waiting.
          if (active_req.expect_mask[1] && it.line_prefix) begin
            sess_flags[mcs_pkg::FL_PREFIX] = 1'b1;
            grab_line(it.line_id);
          end
          // The OK family is tested before the error family.
          if (active_req.expect_mask[2] && it.line_ok) begin
            sess_flags[mcs_pkg::FL_OK] = 1'b1;
            sess_state = mcs_pkg::ST_DONE;
          end else if (active_req.expect_mask[2] && it.line_err) begin
            grab_line(it.line_id);
            sess_flags[mcs_pkg::FL_ERR] = 1'b1;
            sess_state = mcs_pkg::ST_DONE;
          end else if (active_req.expect_mask[3]) begin
            grab_line(it.line_id);
            sess_flags[mcs_pkg::FL_OK] = 1'b1;
            sess_state = mcs_pkg::ST_DONE;
          end
        end
      end
      mcs_pkg::OP_TAKE: begin
        if (sess_state == mcs_pkg::ST_DONE) begin
          r.res_valid      = 1'b1;
          r.res_ok         = sess_flags[mcs_pkg::FL_OK];
          r.res_error      = sess_flags[mcs_pkg::FL_ERR];
          r.res_timed_out  = sess_flags[mcs_pkg::FL_TMO];
          r.res_got_prompt = sess_flags[mcs_pkg::FL_PROMPT];
          r.res_got_prefix = sess_flags[mcs_pkg::FL_PREFIX];
          r.res_has_line   = sess_flags[mcs_pkg::FL_LINE];
          r.res_line_id    = first_line;
          r.res_tag        = active_req.tag;
          sess_flags = '0;
          first_line = '0;
          sess_state = mcs_pkg::ST_IDLE;
        end
      end
      mcs_pkg::OP_RESET: begin
        session_clear();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Transaction builders.
  // ---------------------------------------------------------------------------
  function automatic op_item_t req_op(input logic [2:0] op, input logic [7:0] tag,
                                      input logic [7:0] cmd, input logic [3:0] mask,
                                      input logic [31:0] tmo);
    op_item_t it;
    it = '0;
    it.op = op;
    it.tag = tag;
    it.cmd = cmd;
    it.expect_mask = mask;
    it.timeout = tmo;
    return it;
  endfunction

  function automatic op_item_t tick_op(input logic [31:0] now);
    op_item_t it;
    it = '0;
    it.op = mcs_pkg::OP_TICK;
    it.now_ms = now;
    return it;
  endfunction

  function automatic op_item_t byte_op(input logic [7:0] value);
    op_item_t it;
    it = '0;
    it.op = mcs_pkg::OP_BYTE;
    it.byte_value = value;
    return it;
  endfunction

  function automatic op_item_t line_op(input logic empty, input logic ok, input logic err,
                                       input logic prefix, input logic [7:0] id);
    op_item_t it;
    it = '0;
    it.op = mcs_pkg::OP_LINE;
    it.line_empty = empty;
    it.line_ok = ok;
    it.line_err = err;
    it.line_prefix = prefix;
    it.line_id = id;
    return it;
  endfunction

  function automatic op_item_t bare_op(input logic [2:0] op);
    op_item_t it;
    it = '0;
    it.op = op;
    return it;
  endfunction

  function automatic mcs_pkg::res_t enq_answer(input logic acc);
    mcs_pkg::res_t r;
    r = '0;
    r.accepted = acc;
    return r;
  endfunction

  // A request with random content; timeouts are mostly short so that
  // sessions actually expire, with zero and full-range values mixed in.
  function automatic op_item_t rand_request();
    int          pick;
    logic [31:0] tmo;
    pick = $urandom_range(0, 99);
    if (pick < 10) tmo = $urandom;
    else if (pick < 20) tmo = '0;
    else tmo = $urandom_range(1, 20);
    return req_op(($urandom_range(0, 3) == 0) ? mcs_pkg::OP_ENQ_HIGH : mcs_pkg::OP_ENQ_NORMAL,
                  8'($urandom), 8'($urandom), 4'($urandom_range(0, 15)), tmo);
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int pick;
    if (calm_phase) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic apply_item(input op_item_t it);
    in_operation         = it.op;
    in_now_ms            = it.now_ms;
    in_req_tag           = it.tag;
    in_req_cmd           = it.cmd;
    in_req_expect        = it.expect_mask;
    in_req_timeout_ms    = it.timeout;
    in_byte_value        = it.byte_value;
    in_line_empty        = it.line_empty;
    in_line_is_ok        = it.line_ok;
    in_line_is_error     = it.line_err;
    in_line_prefix_match = it.line_prefix;
    in_line_id           = it.line_id;
  endtask

  task automatic add_row(input op_item_t it, input logic fixed, input mcs_pkg::res_t want);
    row_t row;
    row.item  = it;
    row.fixed = fixed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Presents one transaction at a falling edge, holds it until the block
  // takes it, and records the result the block now owes.
  task automatic send_op(input op_item_t it, input logic fixed, input mcs_pkg::res_t want);
    int            gap;
    mcs_pkg::res_t predicted;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    apply_item(it);
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = session_step(it);
    owed_results.push_back(fixed ? want : predicted);
    ops_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, with stretches of steady readiness.
  // ---------------------------------------------------------------------------
  initial begin : result_pacing
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = pick_gap();
      repeat (stall) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Every result transaction is compared with the oldest owed result.
  always @(posedge clk) begin : result_check
    mcs_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $error("result transaction with no transaction outstanding");
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        check_field("accepted",       32'(want.accepted),       32'(out_accepted));
        check_field("send_valid",     32'(want.send_valid),     32'(out_send_valid));
        check_field("send_cmd",       32'(want.send_cmd),       32'(out_send_cmd));
        check_field("res_valid",      32'(want.res_valid),      32'(out_res_valid));
        check_field("res_ok",         32'(want.res_ok),         32'(out_res_ok));
        check_field("res_error",      32'(want.res_error),      32'(out_res_error));
        check_field("res_timed_out",  32'(want.res_timed_out),  32'(out_res_timed_out));
        check_field("res_got_prompt", 32'(want.res_got_prompt), 32'(out_res_got_prompt));
        check_field("res_got_prefix", 32'(want.res_got_prefix), 32'(out_res_got_prefix));
        check_field("res_has_line",   32'(want.res_has_line),   32'(out_res_has_line));
        check_field("res_line_id",    32'(want.res_line_id),    32'(out_res_line_id));
        check_field("res_tag",        32'(want.res_tag),        32'(out_res_tag));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    op_item_t    it;
    logic [31:0] clock_ms;
    int          kind;
    int          pick;

    rst_n = 1'b0;
    in_valid = 1'b0;
    apply_item('0);
    session_clear();
    clock_ms = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Everything is quiet after reset, so take, byte, line and
    // the unused operation code must all return an empty result.
    add_row(bare_op(mcs_pkg::OP_TAKE), 1'b1, NO_RESULT);
    add_row(byte_op(mcs_pkg::PROMPT_CHAR), 1'b1, NO_RESULT);
    add_row(line_op(1'b0, 1'b1, 1'b0, 1'b0, 8'h01), 1'b1, NO_RESULT);
    add_row(bare_op(OP_IGNORED), 1'b1, NO_RESULT);
    // Field extremes into the normal ring, then fill the high ring until it refuses.
    add_row(req_op(mcs_pkg::OP_ENQ_NORMAL, 8'hff, 8'hff, 4'hf, 32'hffff_ffff), 1'b1,
            enq_answer(1'b1));
    add_row(req_op(mcs_pkg::OP_ENQ_HIGH, 8'h01, 8'h10, 4'h1, 32'h0), 1'b1, enq_answer(1'b1));
    add_row(req_op(mcs_pkg::OP_ENQ_HIGH, 8'h02, 8'h20, 4'h6, 32'd5), 1'b1, enq_answer(1'b1));
    add_row(req_op(mcs_pkg::OP_ENQ_HIGH, 8'h03, 8'h30, 4'h4, 32'd7), 1'b1, enq_answer(1'b1));
    add_row(req_op(mcs_pkg::OP_ENQ_HIGH, 8'h04, 8'h40, 4'h8, 32'd10), 1'b1, enq_answer(1'b1));
    add_row(req_op(mcs_pkg::OP_ENQ_HIGH, 8'h05, 8'h50, 4'hf, 32'd1), 1'b1, enq_answer(1'b0));
    // Prompt session with a zero timeout started at the top of the time range;
    // a non-prompt byte is ignored, then a tick after completion does nothing.
    add_row(tick_op(32'hffff_ffff), 1'b0, NO_RESULT);
    add_row(byte_op(8'h41), 1'b0, NO_RESULT);
    add_row(byte_op(mcs_pkg::PROMPT_CHAR), 1'b0, NO_RESULT);
    add_row(tick_op(32'h0), 1'b0, NO_RESULT);
    add_row(bare_op(mcs_pkg::OP_TAKE), 1'b0, NO_RESULT);
    // Prefix and OK/error session: empty line ignored, prefix line captured
    // without finishing, and a line that is both OK and error ends as OK.
    add_row(tick_op(32'd100), 1'b0, NO_RESULT);
    add_row(line_op(1'b1, 1'b1, 1'b0, 1'b1, 8'h0f), 1'b0, NO_RESULT);
    add_row(line_op(1'b0, 1'b0, 1'b0, 1'b1, 8'h11), 1'b0, NO_RESULT);
    add_row(line_op(1'b0, 1'b1, 1'b1, 1'b0, 8'h22), 1'b0, NO_RESULT);
    add_row(bare_op(mcs_pkg::OP_TAKE), 1'b0, NO_RESULT);
    // Error reply captures its line.
    add_row(tick_op(32'd200), 1'b0, NO_RESULT);
    add_row(line_op(1'b0, 1'b0, 1'b1, 1'b0, 8'h33), 1'b0, NO_RESULT);
    add_row(bare_op(mcs_pkg::OP_TAKE), 1'b0, NO_RESULT);
    // Deadline that wraps past zero: one millisecond early is not yet expired.
    add_row(tick_op(32'hffff_fff8), 1'b0, NO_RESULT);
    add_row(tick_op(32'd1), 1'b0, NO_RESULT);
    add_row(tick_op(32'd2), 1'b0, NO_RESULT);
    add_row(bare_op(mcs_pkg::OP_TAKE), 1'b0, NO_RESULT);
    // The reset operation drops the request still queued in the normal ring.
    add_row(bare_op(mcs_pkg::OP_RESET), 1'b1, NO_RESULT);
    add_row(tick_op(32'd5), 1'b1, NO_RESULT);

    foreach (directed_rows[i])
      send_op(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);

    // Random part. Most of it is complete sessions with random content, the
    // rest is bursts that overflow the rings, reset operations and raw noise.
    while (ops_sent < OP_TARGET) begin
      calm_phase = ($urandom_range(0, 9) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        it.op          = 3'($urandom_range(0, 7));
        it.now_ms      = $urandom;
        it.tag         = 8'($urandom);
        it.cmd         = 8'($urandom);
        it.expect_mask = 4'($urandom);
        it.timeout     = $urandom;
        it.byte_value  = 8'($urandom);
        {it.line_empty, it.line_ok, it.line_err, it.line_prefix} = 4'($urandom_range(0, 15));
        it.line_id     = 8'($urandom);
        send_op(it, 1'b0, NO_RESULT);
      end else if (kind < 11) begin
        send_op(bare_op(mcs_pkg::OP_RESET), 1'b0, NO_RESULT);
      end else if (kind < 25) begin
        repeat ($urandom_range(1, 10)) send_op(rand_request(), 1'b0, NO_RESULT);
      end else begin
        repeat ($urandom_range(0, 2)) send_op(rand_request(), 1'b0, NO_RESULT);
        clock_ms = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms + $urandom_range(0, 5);
        send_op(tick_op(clock_ms), 1'b0, NO_RESULT);
        repeat ($urandom_range(0, 6)) begin
          pick = $urandom_range(0, 99);
          if (pick < 30) begin
            send_op(byte_op(($urandom_range(0, 1) == 0) ? mcs_pkg::PROMPT_CHAR : 8'($urandom)),
                    1'b0, NO_RESULT);
          end else if (pick < 75) begin
            send_op(line_op($urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0,
                            $urandom_range(0, 3) == 0, $urandom_range(0, 1) == 1,
                            8'($urandom)), 1'b0, NO_RESULT);
          end else begin
            pick = $urandom_range(0, 99);
            if (pick < 80) clock_ms = clock_ms + $urandom_range(0, 12);
            else if (pick < 95) clock_ms = clock_ms + $urandom_range(0, 100);
            else clock_ms = $urandom;
            send_op(tick_op(clock_ms), 1'b0, NO_RESULT);
          end
        end
        if ($urandom_range(0, 9) != 0) send_op(bare_op(mcs_pkg::OP_TAKE), 1'b0, NO_RESULT);
      end
    end

    // Drain: every owed result must arrive, then nothing else may follow.
    @(negedge clk);
    in_valid = 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_modem_command_session: PASS");
    end else begin
      $display("tb_modem_command_session: FAIL");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("tb_modem_command_session: FAIL");
    $finish;
  end

endmodule
